[src/lavm_pkg.sv]
// Shared types, widths and arithmetic helpers for the look-at view matrix core.
// Used by every module of the core and by the channel interface payloads.
// No dependencies.
package lavm_pkg;

  localparam int AXES = 3;
  localparam int FW = 32;
  localparam int D_W = 33;
  localparam int W_W = 35;
  localparam int BL_W = 35;
  localparam int LEN_W = 6;
  localparam int MAG_W = 31;
  localparam int SQ_W = 62;
  localparam int SUM_W = 64;
  localparam int ROOT_W = 32;
  localparam int REM_W = 36;
  localparam int SQRT_STEPS = 2;
  localparam int SQRT_STAGES = (ROOT_W + SQRT_STEPS - 1) / SQRT_STEPS;
  localparam int QUO_BITS = 31;
  localparam int NUM_W = 62;
  localparam int DEN_W = 32;
  localparam int DIV_STEPS = 2;
  localparam int DIV_STAGES = (QUO_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int FRAC = 30;
  localparam int PROD_W = 64;
  localparam int DOT_W = 34;
  localparam int LP_W = 66;
  localparam int ROUND_W = 68;

  localparam logic signed [ROUND_W-1:0] ONE_Q30 = ROUND_W'(64'sd1073741824);
  localparam logic signed [ROUND_W-1:0] NEG_ONE_Q30 = -ONE_Q30;
  localparam logic signed [ROUND_W-1:0] SAT_MAX = ROUND_W'(64'sd2147483647);
  localparam logic signed [ROUND_W-1:0] SAT_MIN = ROUND_W'(-64'sd2147483648);
  localparam logic signed [ROUND_W-1:0] HALF_UP = ROUND_W'(64'sd536870912);
  localparam logic signed [ROUND_W-1:0] HALF_DN = ROUND_W'(64'sd536870911);

  typedef logic signed [FW-1:0] fix_t;
  typedef fix_t vec_t [AXES];

  typedef struct packed {
    logic signed [FW-1:0] pos_x;
    logic signed [FW-1:0] pos_y;
    logic signed [FW-1:0] pos_z;
    logic signed [FW-1:0] target_x;
    logic signed [FW-1:0] target_y;
    logic signed [FW-1:0] target_z;
    logic signed [FW-1:0] up_hint_x;
    logic signed [FW-1:0] up_hint_y;
    logic signed [FW-1:0] up_hint_z;
  } req_t;

  typedef struct packed {
    logic signed [FW-1:0] right_x;
    logic signed [FW-1:0] up_x;
    logic signed [FW-1:0] look_x;
    logic signed [FW-1:0] right_y;
    logic signed [FW-1:0] up_y;
    logic signed [FW-1:0] look_y;
    logic signed [FW-1:0] right_z;
    logic signed [FW-1:0] up_z;
    logic signed [FW-1:0] look_z;
    logic signed [FW-1:0] trans_right;
    logic signed [FW-1:0] trans_up;
    logic signed [FW-1:0] trans_look;
  } rsp_t;

  // Shift right by the fraction width, rounding to nearest with ties away from zero.
  function automatic logic signed [ROUND_W-1:0] rnd30(input logic signed [ROUND_W-1:0] v);
    logic signed [ROUND_W-1:0] bias;
    bias = v[ROUND_W-1] ? HALF_DN : HALF_UP;
    return (v + bias) >>> FRAC;
  endfunction

  function automatic logic [LEN_W-1:0] bitlen(input logic [BL_W-1:0] m);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < BL_W; i++) begin
      if (m[i]) begin
        n = LEN_W'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

[src/lavm_chan_if.sv]
// Valid/ready channel that carries one payload per transfer.
// Payload type is given at instantiation, normally a struct from lavm_pkg.
interface lavm_chan_if #(parameter type payload_t = logic);
  logic valid;
  logic ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[src/lavm_isqrt.sv]
// Pipelined floor square root, a fixed number of root bits per stage.
// Depends on lavm_pkg; carries a sideband of any type alongside the data.
module lavm_isqrt #(
  parameter type side_t = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [lavm_pkg::SUM_W-1:0] x,
  input  side_t in_side,
  output logic out_valid,
  output logic [lavm_pkg::ROOT_W-1:0] root,
  output side_t out_side
);

  localparam int NS = lavm_pkg::SQRT_STAGES;
  localparam int RW = lavm_pkg::REM_W;
  localparam int QW = lavm_pkg::ROOT_W;

  logic valid [NS+1];
  logic [lavm_pkg::SUM_W-1:0] xs [NS+1];
  logic [RW-1:0] rem [NS+1];
  logic [QW-1:0] rt [NS+1];
  side_t sd [NS+1];

  assign valid[0] = in_valid;
  assign xs[0] = x;
  assign rem[0] = '0;
  assign rt[0] = '0;
  assign sd[0] = in_side;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [RW-1:0] rem_next;
    logic [QW-1:0] rt_next;

    always_comb begin
      logic [RW-1:0] r;
      logic [RW-1:0] trial;
      logic [QW-1:0] q;
      int t;
      r = rem[k];
      q = rt[k];
      trial = '0;
      t = 0;
      for (int j = 0; j < lavm_pkg::SQRT_STEPS; j++) begin
        t = k * lavm_pkg::SQRT_STEPS + j;
        if (t < QW) begin
          r = {r[RW-3:0], xs[k][2*(QW-1-t) +: 2]};
          trial = RW'({q, 2'b01});
          if (r >= trial) begin
            r = r - trial;
            q = {q[QW-2:0], 1'b1};
          end else begin
            q = {q[QW-2:0], 1'b0};
          end
        end
      end
      rem_next = r;
      rt_next = q;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (en) begin
        valid[k+1] <= valid[k];
      end
      if (en) begin
        xs[k+1] <= xs[k];
        rem[k+1] <= rem_next;
        rt[k+1] <= rt_next;
        sd[k+1] <= sd[k];
      end
    end
  end

  assign out_valid = valid[NS];
  assign root = rt[NS];
  assign out_side = sd[NS];

endmodule

[src/lavm_udiv.sv]
// Pipelined restoring divider, one lane per axis sharing one divisor.
// Depends on lavm_pkg; the quotient is known to stay below 2^31.
module lavm_udiv #(
  parameter type side_t = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [lavm_pkg::NUM_W-1:0] num [lavm_pkg::AXES],
  input  logic [lavm_pkg::DEN_W-1:0] den,
  input  side_t in_side,
  output logic out_valid,
  output logic [lavm_pkg::QUO_BITS-1:0] quo [lavm_pkg::AXES],
  output side_t out_side
);

  localparam int NS = lavm_pkg::DIV_STAGES;
  localparam int NA = lavm_pkg::AXES;
  localparam int DW = lavm_pkg::DEN_W;
  localparam int QB = lavm_pkg::QUO_BITS;
  localparam int NW = lavm_pkg::NUM_W;

  logic valid [NS+1];
  logic [NW-1:0] nm [NS+1][NA];
  logic [DW-1:0] dv [NS+1];
  logic [DW-1:0] rem [NS+1][NA];
  logic [QB-1:0] qt [NS+1][NA];
  side_t sd [NS+1];

  assign valid[0] = in_valid;
  assign dv[0] = den;
  assign sd[0] = in_side;
  for (genvar i = 0; i < NA; i++) begin : g_init
    assign nm[0][i] = num[i];
    assign rem[0][i] = DW'(num[i][NW-1:QB]);
    assign qt[0][i] = '0;
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [DW-1:0] rem_next [NA];
    logic [QB-1:0] qt_next [NA];

    for (genvar i = 0; i < NA; i++) begin : g_lane
      always_comb begin
        logic [DW-1:0] r;
        logic [DW:0] rr;
        logic [QB-1:0] q;
        int t;
        r = rem[k][i];
        q = qt[k][i];
        rr = '0;
        t = 0;
        for (int j = 0; j < lavm_pkg::DIV_STEPS; j++) begin
          t = k * lavm_pkg::DIV_STEPS + j;
          if (t < QB) begin
            rr = {r, nm[k][i][QB-1-t]};
            if (rr >= {1'b0, dv[k]}) begin
              rr = rr - {1'b0, dv[k]};
              q[QB-1-t] = 1'b1;
            end
            r = rr[DW-1:0];
          end
        end
        rem_next[i] = r;
        qt_next[i] = q;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (en) begin
        valid[k+1] <= valid[k];
      end
      if (en) begin
        dv[k+1] <= dv[k];
        sd[k+1] <= sd[k];
        for (int i = 0; i < NA; i++) begin
          nm[k+1][i] <= nm[k][i];
          rem[k+1][i] <= rem_next[i];
          qt[k+1][i] <= qt_next[i];
        end
      end
    end
  end

  assign out_valid = valid[NS];
  assign out_side = sd[NS];
  for (genvar i = 0; i < NA; i++) begin : g_out
    assign quo[i] = qt[NS][i];
  end

endmodule

[src/lavm_norm.sv]
// Vector normalization pipeline: scale by leading one, sum of squares,
// square root and per-axis division. Depends on lavm_pkg, lavm_isqrt, lavm_udiv.
module lavm_norm #(
  parameter int IN_W = 33,
  parameter type side_t = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [IN_W-1:0] vin [lavm_pkg::AXES],
  input  side_t in_side,
  output logic out_valid,
  output lavm_pkg::vec_t vout,
  output side_t out_side
);

  localparam int NA = lavm_pkg::AXES;
  localparam int MW = lavm_pkg::MAG_W;

  typedef struct {
    logic [MW-1:0] c [NA];
    logic [NA-1:0] neg;
    logic zero;
    side_t user;
  } sq_side_t;

  typedef struct {
    logic [NA-1:0] neg;
    logic zero;
    side_t user;
  } dv_side_t;

  logic s1_valid;
  logic [IN_W-1:0] s1_mag [NA];
  logic [NA-1:0] s1_neg;
  logic [lavm_pkg::LEN_W-1:0] s1_len;
  side_t s1_side;

  logic s2_valid;
  sq_side_t s2_side;

  logic s3_valid;
  logic [lavm_pkg::SQ_W-1:0] s3_sq [NA];
  sq_side_t s3_side;

  logic s4_valid;
  logic [lavm_pkg::SUM_W-1:0] s4_sum;
  sq_side_t s4_side;

  logic rt_valid;
  logic [lavm_pkg::ROOT_W-1:0] rt_root;
  sq_side_t rt_side;

  logic s5_valid;
  logic [lavm_pkg::NUM_W-1:0] s5_num [NA];
  logic [lavm_pkg::DEN_W-1:0] s5_den;
  dv_side_t s5_side;

  logic dq_valid;
  logic [lavm_pkg::QUO_BITS-1:0] dq_quo [NA];
  dv_side_t dq_side;

  logic [IN_W-1:0] mag_next [NA];
  logic [IN_W-1:0] mag_or;

  always_comb begin
    mag_or = '0;
    for (int i = 0; i < NA; i++) begin
      mag_next[i] = vin[i][IN_W-1] ? IN_W'(-vin[i]) : IN_W'(vin[i]);
      mag_or = mag_or | mag_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= rt_valid;
      out_valid <= dq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        s1_mag[i] <= mag_next[i];
        s1_neg[i] <= vin[i][IN_W-1];
      end
      s1_len <= lavm_pkg::bitlen(lavm_pkg::BL_W'(mag_or));
      s1_side <= in_side;

      for (int i = 0; i < NA; i++) begin
        s2_side.c[i] <= MW'({s1_mag[i], MW'(0)} >> s1_len);
      end
      s2_side.neg <= s1_neg;
      s2_side.zero <= (s1_len == '0);
      s2_side.user <= s1_side;

      for (int i = 0; i < NA; i++) begin
        s3_sq[i] <= lavm_pkg::SQ_W'(s2_side.c[i]) * lavm_pkg::SQ_W'(s2_side.c[i]);
      end
      s3_side <= s2_side;

      s4_sum <= lavm_pkg::SUM_W'(s3_sq[0]) + lavm_pkg::SUM_W'(s3_sq[1])
              + lavm_pkg::SUM_W'(s3_sq[2]);
      s4_side <= s3_side;

      for (int i = 0; i < NA; i++) begin
        s5_num[i] <= lavm_pkg::NUM_W'({rt_side.c[i], lavm_pkg::FRAC'(0)})
                   + lavm_pkg::NUM_W'(rt_root >> 1);
      end
      s5_den <= rt_root;
      s5_side.neg <= rt_side.neg;
      s5_side.zero <= rt_side.zero;
      s5_side.user <= rt_side.user;

      for (int i = 0; i < NA; i++) begin
        if (dq_side.zero) begin
          vout[i] <= '0;
        end else if (dq_side.neg[i]) begin
          vout[i] <= -lavm_pkg::fix_t'({1'b0, dq_quo[i]});
        end else begin
          vout[i] <= lavm_pkg::fix_t'({1'b0, dq_quo[i]});
        end
      end
      out_side <= dq_side.user;
    end
  end

  lavm_isqrt #(.side_t(sq_side_t)) u_isqrt (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(s4_valid),
    .x(s4_sum),
    .in_side(s4_side),
    .out_valid(rt_valid),
    .root(rt_root),
    .out_side(rt_side)
  );

  lavm_udiv #(.side_t(dv_side_t)) u_udiv (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(s5_valid),
    .num(s5_num),
    .den(s5_den),
    .in_side(s5_side),
    .out_valid(dq_valid),
    .quo(dq_quo),
    .out_side(dq_side)
  );

endmodule

[src/lavm_orth.sv]
// Removes the look component from the up hint: dot product, scale, subtract.
// Depends on lavm_pkg. Four register stages.
module lavm_orth (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  lavm_pkg::vec_t look,
  input  lavm_pkg::vec_t hint,
  input  lavm_pkg::vec_t pos,
  output logic out_valid,
  output logic signed [lavm_pkg::W_W-1:0] w [lavm_pkg::AXES],
  output lavm_pkg::vec_t look_out,
  output lavm_pkg::vec_t pos_out
);

  localparam int NA = lavm_pkg::AXES;
  localparam int RW = lavm_pkg::ROUND_W;

  logic o1_valid, o2_valid, o3_valid;
  logic signed [lavm_pkg::PROD_W-1:0] o1_hp [NA];
  lavm_pkg::vec_t o1_look, o1_hint, o1_pos;
  logic signed [lavm_pkg::DOT_W-1:0] o2_dot;
  lavm_pkg::vec_t o2_look, o2_hint, o2_pos;
  logic signed [lavm_pkg::LP_W-1:0] o3_lp [NA];
  lavm_pkg::vec_t o3_look, o3_hint, o3_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      o1_valid <= 1'b0;
      o2_valid <= 1'b0;
      o3_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      o1_valid <= in_valid;
      o2_valid <= o1_valid;
      o3_valid <= o2_valid;
      out_valid <= o3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        o1_hp[i] <= lavm_pkg::PROD_W'(hint[i]) * lavm_pkg::PROD_W'(look[i]);
      end
      o1_look <= look;
      o1_hint <= hint;
      o1_pos <= pos;

      o2_dot <= lavm_pkg::DOT_W'(lavm_pkg::rnd30(RW'(o1_hp[0]) + RW'(o1_hp[1])
                                                 + RW'(o1_hp[2])));
      o2_look <= o1_look;
      o2_hint <= o1_hint;
      o2_pos <= o1_pos;

      for (int i = 0; i < NA; i++) begin
        o3_lp[i] <= lavm_pkg::LP_W'(o2_look[i]) * lavm_pkg::LP_W'(o2_dot);
      end
      o3_look <= o2_look;
      o3_hint <= o2_hint;
      o3_pos <= o2_pos;

      for (int i = 0; i < NA; i++) begin
        w[i] <= lavm_pkg::W_W'(RW'(o3_hint[i]) - lavm_pkg::rnd30(RW'(o3_lp[i])));
      end
      look_out <= o3_look;
      pos_out <= o3_pos;
    end
  end

endmodule

[src/lavm_frame.sv]
// Builds the right axis as up cross look and the three translations.
// Depends on lavm_pkg. Five register stages.
module lavm_frame (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  lavm_pkg::vec_t up,
  input  lavm_pkg::vec_t look,
  input  lavm_pkg::vec_t pos,
  output logic out_valid,
  output lavm_pkg::vec_t right_out,
  output lavm_pkg::vec_t up_out,
  output lavm_pkg::vec_t look_out,
  output lavm_pkg::vec_t trans
);

  localparam int NA = lavm_pkg::AXES;
  localparam int RW = lavm_pkg::ROUND_W;
  localparam int PW = lavm_pkg::PROD_W;

  logic f1_valid, f2_valid, f3_valid, f4_valid;
  logic signed [PW-1:0] f1_p [2*NA];
  lavm_pkg::vec_t f1_up, f1_look, f1_pos;
  lavm_pkg::vec_t f2_right, f2_up, f2_look, f2_pos;
  logic signed [PW-1:0] f3_pp [NA][NA];
  lavm_pkg::vec_t f3_right, f3_up, f3_look;
  logic signed [RW-1:0] f4_nacc [NA];
  lavm_pkg::vec_t f4_right, f4_up, f4_look;

  logic signed [RW-1:0] cross_rnd [NA];
  logic signed [RW-1:0] trans_rnd [NA];

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      cross_rnd[i] = lavm_pkg::rnd30(RW'(f1_p[2*i]) - RW'(f1_p[2*i+1]));
      trans_rnd[i] = lavm_pkg::rnd30(f4_nacc[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
      f4_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= in_valid;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
      f4_valid <= f3_valid;
      out_valid <= f4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_p[0] <= PW'(up[1]) * PW'(look[2]);
      f1_p[1] <= PW'(up[2]) * PW'(look[1]);
      f1_p[2] <= PW'(up[2]) * PW'(look[0]);
      f1_p[3] <= PW'(up[0]) * PW'(look[2]);
      f1_p[4] <= PW'(up[0]) * PW'(look[1]);
      f1_p[5] <= PW'(up[1]) * PW'(look[0]);
      f1_up <= up;
      f1_look <= look;
      f1_pos <= pos;

      for (int i = 0; i < NA; i++) begin
        if (cross_rnd[i] > lavm_pkg::ONE_Q30) begin
          f2_right[i] <= lavm_pkg::fix_t'(lavm_pkg::ONE_Q30);
        end else if (cross_rnd[i] < lavm_pkg::NEG_ONE_Q30) begin
          f2_right[i] <= lavm_pkg::fix_t'(lavm_pkg::NEG_ONE_Q30);
        end else begin
          f2_right[i] <= lavm_pkg::fix_t'(cross_rnd[i]);
        end
      end
      f2_up <= f1_up;
      f2_look <= f1_look;
      f2_pos <= f1_pos;

      for (int i = 0; i < NA; i++) begin
        f3_pp[0][i] <= PW'(f2_pos[i]) * PW'(f2_right[i]);
        f3_pp[1][i] <= PW'(f2_pos[i]) * PW'(f2_up[i]);
        f3_pp[2][i] <= PW'(f2_pos[i]) * PW'(f2_look[i]);
      end
      f3_right <= f2_right;
      f3_up <= f2_up;
      f3_look <= f2_look;

      for (int j = 0; j < NA; j++) begin
        f4_nacc[j] <= RW'(0) - RW'(f3_pp[j][0]) - RW'(f3_pp[j][1]) - RW'(f3_pp[j][2]);
      end
      f4_right <= f3_right;
      f4_up <= f3_up;
      f4_look <= f3_look;

      for (int j = 0; j < NA; j++) begin
        if (trans_rnd[j] > lavm_pkg::SAT_MAX) begin
          trans[j] <= lavm_pkg::fix_t'(lavm_pkg::SAT_MAX);
        end else if (trans_rnd[j] < lavm_pkg::SAT_MIN) begin
          trans[j] <= lavm_pkg::fix_t'(lavm_pkg::SAT_MIN);
        end else begin
          trans[j] <= lavm_pkg::fix_t'(trans_rnd[j]);
        end
      end
      right_out <= f4_right;
      up_out <= f4_up;
      look_out <= f4_look;
    end
  end

endmodule

[src/look_at_view_matrix_core.sv]
// Top level of the look-at view matrix core: input register, two normalizers,
// orthogonalization, frame build and output register. Depends on lavm_pkg,
// lavm_chan_if, lavm_norm, lavm_orth and lavm_frame.
//
//   channel  role    payload  contents
//   req      sink    req_t    camera position, target point, up hint (Q16.16)
//   rsp      source  rsp_t    rotation in Q2.30, translation in Q16.16
//
// One transfer is accepted every cycle unless rsp stalls the pipeline; the square
// root and divider stages of the two normalizers resolve two bits per stage.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
// The whole pipeline advances together whenever the output register is empty or
// being taken, so a stall on rsp holds every stage and drops nothing.
module look_at_view_matrix_core (
  input logic clk,
  input logic rst,
  lavm_chan_if.sink req,
  lavm_chan_if.source rsp
);

  localparam int NA = lavm_pkg::AXES;

  typedef struct {
    lavm_pkg::vec_t hint;
    lavm_pkg::vec_t pos;
  } look_side_t;

  typedef struct {
    lavm_pkg::vec_t look;
    lavm_pkg::vec_t pos;
  } up_side_t;

  logic en;
  logic s0_valid;
  logic signed [lavm_pkg::D_W-1:0] s0_d [NA];
  look_side_t s0_side;

  logic look_valid;
  lavm_pkg::vec_t look_vec;
  look_side_t look_side;

  logic orth_valid;
  logic signed [lavm_pkg::W_W-1:0] orth_w [NA];
  up_side_t orth_side;

  logic up_valid;
  lavm_pkg::vec_t up_vec;
  up_side_t up_side;

  logic frame_valid;
  lavm_pkg::vec_t fr_right, fr_up, fr_look, fr_trans;

  logic out_valid;
  lavm_pkg::rsp_t out_data;

  lavm_pkg::vec_t in_pos, in_tgt, in_hint;

  assign en = !out_valid || rsp.ready;
  assign req.ready = en;
  assign rsp.valid = out_valid;
  assign rsp.data = out_data;

  assign in_pos[0] = req.data.pos_x;
  assign in_pos[1] = req.data.pos_y;
  assign in_pos[2] = req.data.pos_z;
  assign in_tgt[0] = req.data.target_x;
  assign in_tgt[1] = req.data.target_y;
  assign in_tgt[2] = req.data.target_z;
  assign in_hint[0] = req.data.up_hint_x;
  assign in_hint[1] = req.data.up_hint_y;
  assign in_hint[2] = req.data.up_hint_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= req.valid;
      out_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        s0_d[i] <= lavm_pkg::D_W'(in_tgt[i]) - lavm_pkg::D_W'(in_pos[i]);
      end
      s0_side.hint <= in_hint;
      s0_side.pos <= in_pos;

      out_data.right_x <= fr_right[0];
      out_data.right_y <= fr_right[1];
      out_data.right_z <= fr_right[2];
      out_data.up_x <= fr_up[0];
      out_data.up_y <= fr_up[1];
      out_data.up_z <= fr_up[2];
      out_data.look_x <= fr_look[0];
      out_data.look_y <= fr_look[1];
      out_data.look_z <= fr_look[2];
      out_data.trans_right <= fr_trans[0];
      out_data.trans_up <= fr_trans[1];
      out_data.trans_look <= fr_trans[2];
    end
  end

  lavm_norm #(.IN_W(lavm_pkg::D_W), .side_t(look_side_t)) u_norm_look (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(s0_valid),
    .vin(s0_d),
    .in_side(s0_side),
    .out_valid(look_valid),
    .vout(look_vec),
    .out_side(look_side)
  );

  lavm_orth u_orth (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(look_valid),
    .look(look_vec),
    .hint(look_side.hint),
    .pos(look_side.pos),
    .out_valid(orth_valid),
    .w(orth_w),
    .look_out(orth_side.look),
    .pos_out(orth_side.pos)
  );

  lavm_norm #(.IN_W(lavm_pkg::W_W), .side_t(up_side_t)) u_norm_up (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(orth_valid),
    .vin(orth_w),
    .in_side(orth_side),
    .out_valid(up_valid),
    .vout(up_vec),
    .out_side(up_side)
  );

  lavm_frame u_frame (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(up_valid),
    .up(up_vec),
    .look(up_side.look),
    .pos(up_side.pos),
    .out_valid(frame_valid),
    .right_out(fr_right),
    .up_out(fr_up),
    .look_out(fr_look),
    .trans(fr_trans)
  );

endmodule
